// ===== hw/rtl/bf3_pkg.sv =====
// Shared types and constants of the 3x3 RGB box filter.
`timescale 1ns / 1ps
package bf3_pkg;

  // Width of one channel field on the stream ports
  localparam int unsigned ChanPortW = 16;
  // Width of the frame size register
  localparam int unsigned CfgW      = 10;
  // Reset value of the frame size register
  localparam int unsigned CfgReset  = 512;
  // Depth of the queue of pending windows
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  // Result kinds an input can cause, in raster order
  localparam int unsigned JobAboveLeft = 0;  // (r-1, c-1)
  localparam int unsigned JobAbove     = 1;  // (r-1, c) at the right edge
  localparam int unsigned JobLeft      = 2;  // (r, c-1) in the last row
  localparam int unsigned JobHere      = 3;  // (r, c) at the last pixel
  localparam int unsigned NumJobs      = 4;

  // Divisor handling after the pre-shift
  typedef enum logic [1:0] {
    DIV_NONE = 2'd0,
    DIV_3    = 2'd1,
    DIV_9    = 2'd2
  } div_mode_e;

  // Per-window control: which window rows and columns lie inside the frame,
  // and which results the window finishes
  typedef struct packed {
    logic [2:0]         row_in;
    logic [2:0]         col_in;
    logic [NumJobs-1:0] jobs;
  } bf3_ctl_t;

endpackage

// ===== hw/rtl/box_filter_3x3_rgb.sv =====
// Top level of the streaming 3x3 mean filter for square RGB frames.
//
// Pixels enter on the s_axis channel in raster order, one transaction per
// pixel. Each smoothed pixel leaves on m_axis with its row and column; tlast
// marks the final pixel of the frame and tuser the last result caused by an
// input pixel. A result is produced once the pixel below-right of it has
// arrived; in the last row every input also finishes pixels of its own row,
// so one input can cause up to four results.
// Inputs pass stage 1 and the window queue, results the sum stage and the
// output register. Throughput without stalls: one pixel per cycle, set by
// the line buffer read-modify-write (one read and one write per cycle); in the
// last row the output issues one result per cycle and the input paces to it.
// cfg_we_i writes the frame size (1..MaxSide, 0 acts as 1) and restarts the
// frame; write it only while the block is idle.
// Reset sets the frame size to 512 and the position to pixel (0,0). Line
// buffer contents are not cleared; unwritten entries only ever fall outside
// the frame and are masked. When m_axis stalls, a four-window queue absorbs
// input, then s_axis_tready drops.
`timescale 1ns / 1ps
module box_filter_3x3_rgb import bf3_pkg::*; #(
  parameter int unsigned MaxSide = 512,
  parameter int unsigned ChanW   = 16,
  localparam int unsigned PosW   = $clog2(MaxSide),
  localparam int unsigned OutW   = ((3 * ChanPortW + 2 * PosW + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [3*ChanPortW-1:0] s_axis_tdata,   // in_red, in_green, in_blue
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutW-1:0]        m_axis_tdata,   // out_red, out_green, out_blue,
                                                 // out_row, out_col, zero pad
  output logic                   m_axis_tlast,   // frame_done
  output logic                   m_axis_tuser    // run_last
);

  localparam int unsigned PixW = 3 * ChanW;

  logic [PixW-1:0]                in_pix;
  logic [FifoCntW-1:0]            fifo_cnt;
  logic                           mem_rd_en, mem_wr_en;
  logic [PosW-1:0]                mem_rd_addr, mem_wr_addr;
  logic [2*PixW-1:0]              mem_rd_data, mem_wr_data;
  logic                           push;
  logic [2:0][2:0][PixW-1:0]      push_win;
  bf3_ctl_t                       push_ctl;
  logic [PosW-1:0]                push_row, push_col;
  logic [2:0][ChanW-1:0]          out_chan;
  logic [PosW-1:0]                out_row, out_col;

  // Keep the low channel bits of each field
  assign in_pix = {s_axis_tdata[2*ChanPortW +: ChanW],
                   s_axis_tdata[ChanPortW +: ChanW],
                   s_axis_tdata[0 +: ChanW]};

  bf3_lbuf #(
    .Depth (MaxSide),
    .DataW (2 * PixW)
  ) u_lbuf (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  bf3_front #(
    .MaxSide (MaxSide),
    .ChanW   (ChanW),
    .PosW    (PosW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_pix_i      (in_pix),
    .fifo_cnt_i    (fifo_cnt),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .push_o        (push),
    .push_win_o    (push_win),
    .push_ctl_o    (push_ctl),
    .push_row_o    (push_row),
    .push_col_o    (push_col)
  );

  bf3_mean #(
    .ChanW (ChanW),
    .PosW  (PosW)
  ) u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_win_i  (push_win),
    .push_ctl_i  (push_ctl),
    .push_row_i  (push_row),
    .push_col_i  (push_col),
    .fifo_cnt_o  (fifo_cnt),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_chan_o  (out_chan),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_done_o  (m_axis_tlast),
    .out_last_o  (m_axis_tuser)
  );

  // Pack the result fields, first field lowest
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[0 +: ChanPortW]                 = ChanPortW'(out_chan[0]);
    m_axis_tdata[ChanPortW +: ChanPortW]         = ChanPortW'(out_chan[1]);
    m_axis_tdata[2*ChanPortW +: ChanPortW]       = ChanPortW'(out_chan[2]);
    m_axis_tdata[3*ChanPortW +: PosW]            = out_row;
    m_axis_tdata[3*ChanPortW + PosW +: PosW]     = out_col;
  end

endmodule

// ===== hw/rtl/bf3_lbuf.sv =====
// Line buffer memory holding the two rows above the current one.
`timescale 1ns / 1ps
module bf3_lbuf #(
  parameter int unsigned Depth = 512,
  parameter int unsigned DataW = 96
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [DataW-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [DataW-1:0]         wr_data_i
);

  logic [DataW-1:0] line_mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= line_mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/bf3_front.sv =====
// Input side: position counters, line buffer read-modify-write and 3x3 window.
`timescale 1ns / 1ps
module bf3_front import bf3_pkg::*; #(
  parameter int unsigned MaxSide = 512,
  parameter int unsigned ChanW   = 16,
  parameter int unsigned PosW    = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CfgW-1:0]               cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3*ChanW-1:0]            in_pix_i,
  input  logic [FifoCntW-1:0]           fifo_cnt_i,
  output logic                          mem_rd_en_o,
  output logic [PosW-1:0]               mem_rd_addr_o,
  input  logic [6*ChanW-1:0]            mem_rd_data_i,
  output logic                          mem_wr_en_o,
  output logic [PosW-1:0]               mem_wr_addr_o,
  output logic [6*ChanW-1:0]            mem_wr_data_o,
  output logic                          push_o,
  output logic [2:0][2:0][3*ChanW-1:0]  push_win_o,
  output bf3_ctl_t                      push_ctl_o,
  output logic [PosW-1:0]               push_row_o,
  output logic [PosW-1:0]               push_col_o
);

  localparam int unsigned PixW = 3 * ChanW;

  logic [CfgW-1:0] fs_q;
  logic [PosW-1:0] row_q, col_q;
  logic [31:0]     side;
  logic [PosW-1:0] last;
  logic            accept;

  logic            s1_v_q;
  logic [PixW-1:0] s1_pix_q;
  logic [PosW-1:0] s1_row_q, s1_col_q;
  bf3_ctl_t        s1_ctl_q, s0_ctl;

  logic [2:0][2:0][PixW-1:0] win_q, win_d;
  logic [PixW-1:0]           two_up, one_up;

  // Effective side length, clamped to 1..MaxSide
  always_comb begin
    if (fs_q == '0) begin
      side = 32'd1;
    end else if (32'(fs_q) > 32'(MaxSide)) begin
      side = 32'(MaxSide);
    end else begin
      side = 32'(fs_q);
    end
    last = PosW'(side - 32'd1);
  end

  // Room is kept in the window queue for this transaction and the one in flight
  assign in_ready_o = (32'(fifo_cnt_i) + 32'(s1_v_q)) < 32'(FifoDepth);
  assign accept     = in_valid_i && in_ready_o;

  // Frame size register and raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q  <= CfgW'(CfgReset);
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_we_i) begin
      fs_q  <= cfg_wdata_i;
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (col_q == last) begin
        col_q <= '0;
        row_q <= (row_q == last) ? '0 : row_q + PosW'(1);
      end else begin
        col_q <= col_q + PosW'(1);
      end
    end
  end

  // Which window rows/columns are in frame and which results this pixel completes
  always_comb begin
    s0_ctl.row_in = {1'b1, row_q != '0, row_q > PosW'(1)};
    s0_ctl.col_in = {1'b1, col_q != '0, col_q > PosW'(1)};
    s0_ctl.jobs[JobAboveLeft] = (row_q != '0) && (col_q != '0);
    s0_ctl.jobs[JobAbove]     = (row_q != '0) && (col_q == last);
    s0_ctl.jobs[JobLeft]      = (row_q == last) && (col_q != '0);
    s0_ctl.jobs[JobHere]      = (row_q == last) && (col_q == last);
  end

  assign mem_rd_en_o   = accept;
  assign mem_rd_addr_o = col_q;

  // Stage 1 holds the pixel while the line buffer read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= in_pix_i;
      s1_row_q <= row_q;
      s1_col_q <= col_q;
      s1_ctl_q <= s0_ctl;
    end
  end

  assign two_up = mem_rd_data_i[6*ChanW-1:PixW];
  assign one_up = mem_rd_data_i[PixW-1:0];

  // Window shifts one column left; the new column comes from the line buffer and the stage 1 pixel
  always_comb begin
    win_d = win_q;
    if (s1_v_q) begin
      for (int w = 0; w < 3; w++) begin
        win_d[w][0] = win_q[w][1];
        win_d[w][1] = win_q[w][2];
      end
      win_d[0][2] = two_up;
      win_d[1][2] = one_up;
      win_d[2][2] = s1_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // Line buffer write-back: each column moves up by one row
  assign mem_wr_en_o   = s1_v_q;
  assign mem_wr_addr_o = s1_col_q;
  assign mem_wr_data_o = {one_up, s1_pix_q};

  assign push_o     = s1_v_q && (s1_ctl_q.jobs != '0);
  assign push_win_o = win_d;
  assign push_ctl_o = s1_ctl_q;
  assign push_row_o = s1_row_q;
  assign push_col_o = s1_col_q;

endmodule

// ===== hw/rtl/bf3_mean.sv =====
// Window queue, neighbourhood sums and division by the neighbour count.
`timescale 1ns / 1ps
module bf3_mean import bf3_pkg::*; #(
  parameter int unsigned ChanW = 16,
  parameter int unsigned PosW  = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [2:0][2:0][3*ChanW-1:0]  push_win_i,
  input  bf3_ctl_t                      push_ctl_i,
  input  logic [PosW-1:0]               push_row_i,
  input  logic [PosW-1:0]               push_col_i,
  output logic [FifoCntW-1:0]           fifo_cnt_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0][ChanW-1:0]         out_chan_o,
  output logic [PosW-1:0]               out_row_o,
  output logic [PosW-1:0]               out_col_o,
  output logic                          out_done_o,
  output logic                          out_last_o
);

  localparam int unsigned PixW = 3 * ChanW;
  localparam int unsigned SumW = ChanW + 4;
  localparam int unsigned RecK = SumW + 4;
  localparam int unsigned MulW = SumW + 3;
  localparam logic [MulW-1:0] Recip3 = MulW'((2 ** RecK + 2) / 3);
  localparam logic [MulW-1:0] Recip9 = MulW'((2 ** RecK + 8) / 9);

  // Window queue
  logic [2:0][2:0][PixW-1:0] fifo_win_q [FifoDepth];
  bf3_ctl_t                  fifo_ctl_q [FifoDepth];
  logic [PosW-1:0]           fifo_row_q [FifoDepth];
  logic [PosW-1:0]           fifo_col_q [FifoDepth];
  logic [FifoPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]       cnt_q;
  logic [NumJobs-1:0]        served_q;

  logic [2:0][2:0][PixW-1:0] head_win;
  bf3_ctl_t                  head_ctl;
  logic [PosW-1:0]           head_row, head_col;
  logic [NumJobs-1:0]        remaining, pick;
  logic                      issue, pop, last_job;
  logic [2:0]                row_m, col_m;
  logic [1:0]                row_n, col_n;
  logic [3:0]                nbr_cnt;
  logic [2:0][SumW-1:0]      sum;
  logic [1:0]                sh;
  div_mode_e                 mode;

  logic                      e1_v_q, e1_adv;
  logic [2:0][SumW-1:0]      e1_sum_q;
  logic [1:0]                e1_sh_q;
  div_mode_e                 e1_mode_q;
  logic [PosW-1:0]           e1_row_q, e1_col_q;
  logic                      e1_done_q, e1_last_q;

  logic                      out_v_q, out_adv;
  logic [2:0][ChanW-1:0]     out_chan_q, quot;
  logic [PosW-1:0]           out_row_q, out_col_q;
  logic                      out_done_q, out_last_q;

  assign head_win = fifo_win_q[rd_ptr_q];
  assign head_ctl = fifo_ctl_q[rd_ptr_q];
  assign head_row = fifo_row_q[rd_ptr_q];
  assign head_col = fifo_col_q[rd_ptr_q];

  // Next result of the head window, in raster order
  assign remaining = head_ctl.jobs & ~served_q;
  always_comb begin
    pick = '0;
    priority if (remaining[JobAboveLeft]) begin
      pick[JobAboveLeft] = 1'b1;
    end else if (remaining[JobAbove]) begin
      pick[JobAbove] = 1'b1;
    end else if (remaining[JobLeft]) begin
      pick[JobLeft] = 1'b1;
    end else if (remaining[JobHere]) begin
      pick[JobHere] = 1'b1;
    end else begin
      pick = '0;
    end
  end

  assign out_adv  = !out_v_q || out_ready_i;
  assign e1_adv   = !e1_v_q || out_adv;
  assign issue    = (cnt_q != '0) && e1_adv;
  assign last_job = (remaining & ~pick) == '0;
  assign pop      = issue && last_job;

  // Queue pointers and per-window progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      served_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
        served_q <= '0;
      end else if (issue) begin
        served_q <= served_q | pick;
      end
      cnt_q <= cnt_q + FifoCntW'(push_i) - FifoCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_win_q[wr_ptr_q] <= push_win_i;
      fifo_ctl_q[wr_ptr_q] <= push_ctl_i;
      fifo_row_q[wr_ptr_q] <= push_row_i;
      fifo_col_q[wr_ptr_q] <= push_col_i;
    end
  end

  assign fifo_cnt_o = cnt_q;

  // Neighbour mask: results in the current row drop the top window row,
  // results in the current column drop the leftmost window column
  always_comb begin
    row_m = (pick[JobLeft] || pick[JobHere]) ? (head_ctl.row_in & 3'b110)
                                             : head_ctl.row_in;
    col_m = (pick[JobAbove] || pick[JobHere]) ? (head_ctl.col_in & 3'b110)
                                              : head_ctl.col_in;
    row_n   = 2'($countones(row_m));
    col_n   = 2'($countones(col_m));
    nbr_cnt = 4'(row_n) * 4'(col_n);
  end

  // Per-channel sums over the masked window
  always_comb begin
    sum = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int w = 0; w < 3; w++) begin
        for (int k = 0; k < 3; k++) begin
          if (row_m[w] && col_m[k]) begin
            sum[ch] = sum[ch] + SumW'(head_win[w][k][ch*ChanW +: ChanW]);
          end
        end
      end
    end
  end

  // Divisor as pre-shift plus optional reciprocal
  always_comb begin
    unique case (nbr_cnt)
      4'd2:    begin sh = 2'd1; mode = DIV_NONE; end
      4'd3:    begin sh = 2'd0; mode = DIV_3;    end
      4'd4:    begin sh = 2'd2; mode = DIV_NONE; end
      4'd6:    begin sh = 2'd1; mode = DIV_3;    end
      4'd9:    begin sh = 2'd0; mode = DIV_9;    end
      default: begin sh = 2'd0; mode = DIV_NONE; end
    endcase
  end

  // Sum stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
    end else if (e1_adv) begin
      e1_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      e1_sum_q  <= sum;
      e1_sh_q   <= sh;
      e1_mode_q <= mode;
      e1_row_q  <= (pick[JobAboveLeft] || pick[JobAbove]) ? head_row - PosW'(1)
                                                          : head_row;
      e1_col_q  <= (pick[JobAboveLeft] || pick[JobLeft]) ? head_col - PosW'(1)
                                                         : head_col;
      e1_done_q <= pick[JobHere];
      e1_last_q <= last_job;
    end
  end

  // Division by pre-shift and, for DIV_3 and DIV_9, reciprocal multiplication
  always_comb begin
    logic [SumW-1:0]      t;
    logic [SumW+MulW-1:0] prod;
    for (int ch = 0; ch < 3; ch++) begin
      t = e1_sum_q[ch] >> e1_sh_q;
      unique case (e1_mode_q)
        DIV_3:   prod = (SumW+MulW)'(t) * (SumW+MulW)'(Recip3);
        DIV_9:   prod = (SumW+MulW)'(t) * (SumW+MulW)'(Recip9);
        default: prod = '0;
      endcase
      if (e1_mode_q == DIV_NONE) begin
        quot[ch] = t[ChanW-1:0];
      end else begin
        quot[ch] = prod[RecK +: ChanW];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= e1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && e1_v_q) begin
      out_chan_q <= quot;
      out_row_q  <= e1_row_q;
      out_col_q  <= e1_col_q;
      out_done_q <= e1_done_q;
      out_last_q <= e1_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_chan_o  = out_chan_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_done_o  = out_done_q;
  assign out_last_o  = out_last_q;

endmodule
